// File: hw/rtl/mscc_pkg.sv
package mscc_pkg;

  localparam int SET_COUNT  = 64;
  localparam int LINE_WORDS = 4;
  localparam int ADDR_BITS  = 20;
  localparam int DATA_W     = 32;

  localparam int OFF_BITS   = $clog2(LINE_WORDS);
  localparam int IDX_BITS   = $clog2(SET_COUNT);
  localparam int TAG_BITS   = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int WADDR_BITS = IDX_BITS + OFF_BITS;
  localparam int LEFT_BITS  = OFF_BITS + 1;
  localparam int PADDR_W    = 3;

  typedef logic [ADDR_BITS-1:0]  addr_t;
  typedef logic [DATA_W-1:0]     word_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [TAG_BITS-1:0]   tag_t;
  typedef logic [OFF_BITS-1:0]   off_t;
  typedef logic [WADDR_BITS-1:0] waddr_t;
  typedef logic [LEFT_BITS-1:0]  left_t;

  typedef enum logic [1:0] {
    MESI_I = 2'd0,
    MESI_S = 2'd1,
    MESI_E = 2'd2,
    MESI_M = 2'd3
  } mesi_e;

  typedef enum logic [1:0] {
    BUS_NONE  = 2'd0,
    BUS_RD    = 2'd1,
    BUS_RDX   = 2'd2,
    BUS_WRBK  = 2'd3
  } bus_cmd_e;

  typedef enum logic [1:0] {
    REQ_READ    = 2'd0,
    REQ_WRITE   = 2'd1,
    REQ_OBSERVE = 2'd2,
    REQ_TICK    = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_META,
    ST_WORD,
    ST_EXEC,
    ST_MERGE,
    ST_RESP
  } state_e;

  localparam logic [PADDR_W-1:0] REG_CORE_ID = PADDR_W'(0);

  typedef struct packed {
    logic capture;
    logic meta_rd;
    logic word_rd;
    logic exec;
    logic merge;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_merge;
  } dp_status_t;

  function automatic idx_t a_idx(addr_t a);
    return a[OFF_BITS +: IDX_BITS];
  endfunction

  function automatic tag_t a_tag(addr_t a);
    return a[ADDR_BITS-1 -: TAG_BITS];
  endfunction

  function automatic off_t a_off(addr_t a);
    return a[OFF_BITS-1:0];
  endfunction

endpackage

// File: hw/rtl/mscc_if.sv
interface mscc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [19:0] address;
  logic [31:0] wr_word;
  logic [1:0]  bus_cmd;
  logic [1:0]  bus_origin;
  logic [19:0] bus_address;
  logic [31:0] bus_word;
  logic        shr_line;

  modport source (output valid, req_type, address, wr_word, bus_cmd, bus_origin,
                  bus_address, bus_word, shr_line, input ready);
  modport sink (input valid, req_type, address, wr_word, bus_cmd, bus_origin,
                bus_address, bus_word, shr_line, output ready);
endinterface

interface mscc_rsp_if;
  logic        valid;
  logic        ready;
  logic        ready_res;
  logic [31:0] read_data;
  logic        bus_req_valid;
  logic [1:0]  bus_req_cmd;
  logic [19:0] bus_req_addr;
  logic [31:0] bus_req_data;
  logic        assert_shared;

  modport source (output valid, ready_res, read_data, bus_req_valid, bus_req_cmd,
                  bus_req_addr, bus_req_data, assert_shared, input ready);
  modport sink (input valid, ready_res, read_data, bus_req_valid, bus_req_cmd,
                bus_req_addr, bus_req_data, assert_shared, output ready);
endinterface

// File: hw/rtl/mscc_ctrl.sv
module mscc_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  mscc_pkg::dp_status_t   status_i,
  output mscc_pkg::ctrl_cmd_t    cmd_o
);
  import mscc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_META;
        end
      end
      ST_META: begin
        cmd_o.meta_rd = 1'b1;
        state_d       = ST_WORD;
      end
      ST_WORD: begin
        cmd_o.word_rd = 1'b1;
        state_d       = ST_EXEC;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_merge ? ST_MERGE : ST_RESP;
      end
      ST_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = ST_RESP;
      end
      ST_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mscc_dp.sv
module mscc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mscc_pkg::ctrl_cmd_t  cmd_i,
  output mscc_pkg::dp_status_t status_o,
  input  logic [1:0]           core_id_i,
  input  logic [1:0]           req_type_i,
  input  mscc_pkg::addr_t      address_i,
  input  mscc_pkg::word_t      wr_word_i,
  input  logic [1:0]           bus_cmd_i,
  input  logic [1:0]           bus_origin_i,
  input  mscc_pkg::addr_t      bus_address_i,
  input  mscc_pkg::word_t      bus_word_i,
  input  logic                 shr_line_i,
  output logic                 ready_res_o,
  output mscc_pkg::word_t      read_data_o,
  output logic                 bus_req_valid_o,
  output logic [1:0]           bus_req_cmd_o,
  output mscc_pkg::addr_t      bus_req_addr_o,
  output mscc_pkg::word_t      bus_req_data_o,
  output logic                 assert_shared_o
);
  import mscc_pkg::*;

  req_type_e it_type_q;
  addr_t     it_addr_q, it_baddr_q;
  word_t     it_wdata_q, it_bword_q;
  bus_cmd_e  it_cmd_q;
  logic [1:0] it_origin_q;
  logic      it_shared_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      it_type_q   <= req_type_e'(req_type_i);
      it_addr_q   <= address_i;
      it_wdata_q  <= wr_word_i;
      it_cmd_q    <= bus_cmd_e'(bus_cmd_i);
      it_origin_q <= bus_origin_i;
      it_baddr_q  <= bus_address_i;
      it_bword_q  <= bus_word_i;
      it_shared_q <= shr_line_i;
    end
  end

  logic  miss_q, miss_d, pw_q, pw_d, ogs_q, ogs_d;
  logic  sfa_q, sfa_d, ea_q, ea_d;
  addr_t paddr_q, paddr_d, sfbase_q, sfbase_d;
  word_t pword_q, pword_d;
  left_t left_q, left_d;
  off_t  ewi_q, ewi_d;
  logic [SET_COUNT-1:0] mvalid_q, mvalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q   <= 1'b0;
      pw_q     <= 1'b0;
      ogs_q    <= 1'b0;
      sfa_q    <= 1'b0;
      ea_q     <= 1'b0;
      paddr_q  <= '0;
      sfbase_q <= '0;
      pword_q  <= '0;
      left_q   <= '0;
      ewi_q    <= '0;
      mvalid_q <= '0;
    end else if (cmd_i.exec) begin
      miss_q   <= miss_d;
      pw_q     <= pw_d;
      ogs_q    <= ogs_d;
      sfa_q    <= sfa_d;
      ea_q     <= ea_d;
      paddr_q  <= paddr_d;
      sfbase_q <= sfbase_d;
      pword_q  <= pword_d;
      left_q   <= left_d;
      ewi_q    <= ewi_d;
      mvalid_q <= mvalid_d;
    end
  end

  logic [TAG_BITS+1:0] meta_mem [SET_COUNT];
  logic [TAG_BITS+1:0] meta_q;
  word_t               word_mem [SET_COUNT*LINE_WORDS];
  word_t               word_q;

  addr_t  maddr;
  idx_t   idx;
  tag_t   cur_tag;
  mesi_e  cur_st;
  logic   mwe;
  mesi_e  mw_st;
  tag_t   mw_tag;
  logic   wwe;
  waddr_t wwa, wra;
  word_t  wwd;

  always_comb begin
    unique case (it_type_q)
      REQ_READ, REQ_WRITE: maddr = it_addr_q;
      REQ_OBSERVE:         maddr = it_baddr_q;
      default:             maddr = sfbase_q;
    endcase
  end

  assign idx     = a_idx(maddr);
  assign cur_tag = mvalid_q[idx] ? meta_q[TAG_BITS+1:2] : '0;
  assign cur_st  = mvalid_q[idx] ? mesi_e'(meta_q[1:0]) : MESI_I;

  always_ff @(posedge clk_i) begin
    if (mwe) begin
      meta_mem[idx] <= {mw_tag, mw_st};
    end
    if (cmd_i.meta_rd) begin
      meta_q <= meta_mem[idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wwe) begin
      word_mem[wwa] <= wwd;
    end
    if (cmd_i.word_rd) begin
      word_q <= word_mem[wra];
    end
  end

  logic  is_wr, tag_hit, rd_hit, wr_match, wr_ok, do_evict, ev_last;
  off_t  ev_w, tw;
  logic  own, snoop_hit, fill, fill_last;

  assign is_wr    = (it_type_q == REQ_WRITE);
  assign tag_hit  = (cur_tag == a_tag(maddr));
  assign rd_hit   = !is_wr && tag_hit && (cur_st != MESI_I);
  assign wr_match = is_wr && tag_hit;
  assign wr_ok    = wr_match && (cur_st == MESI_M || cur_st == MESI_E);
  assign do_evict = !rd_hit && !wr_match && (ea_q || cur_st == MESI_M);
  assign ev_w     = ea_q ? ewi_q : '0;
  assign ev_last  = (ev_w == OFF_BITS'(LINE_WORDS - 1));
  assign tw       = OFF_BITS'(LEFT_BITS'(LINE_WORDS) - left_q);

  assign own       = (it_origin_q == core_id_i) && (it_cmd_q == BUS_RD || it_cmd_q == BUS_RDX);
  assign snoop_hit = tag_hit && (cur_st != MESI_I);
  assign fill      = !own && miss_q && ogs_q && (it_cmd_q == BUS_WRBK);
  assign fill_last = fill && (a_off(it_baddr_q) == OFF_BITS'(LINE_WORDS - 1));

  assign status_o.need_merge = (it_type_q == REQ_OBSERVE) && fill_last && pw_q;

  always_comb begin
    if (it_type_q == REQ_TICK) begin
      wra = {idx, tw};
    end else begin
      wra = {idx, rd_hit ? a_off(it_addr_q) : ev_w};
    end
  end

  logic  r_ready, r_valid, r_shared;
  word_t r_rdata, r_data;
  bus_cmd_e r_cmd;
  addr_t r_addr;

  always_comb begin
    miss_d   = miss_q;
    pw_d     = pw_q;
    ogs_d    = ogs_q;
    sfa_d    = sfa_q;
    ea_d     = ea_q;
    paddr_d  = paddr_q;
    sfbase_d = sfbase_q;
    pword_d  = pword_q;
    left_d   = left_q;
    ewi_d    = ewi_q;
    mvalid_d = mvalid_q;
    mwe      = 1'b0;
    mw_st    = cur_st;
    mw_tag   = cur_tag;
    wwe      = 1'b0;
    wwa      = {idx, a_off(maddr)};
    wwd      = it_wdata_q;
    r_ready  = 1'b0;
    r_rdata  = '0;
    r_valid  = 1'b0;
    r_cmd    = BUS_NONE;
    r_addr   = '0;
    r_data   = '0;
    r_shared = 1'b0;
    unique case (it_type_q)
      REQ_READ, REQ_WRITE: begin
        if (!(miss_q || sfa_q)) begin
          if (rd_hit) begin
            r_ready = 1'b1;
            r_rdata = word_q;
            ogs_d   = 1'b0;
          end else if (wr_ok) begin
            wwe     = 1'b1;
            mwe     = 1'b1;
            mw_st   = MESI_M;
            r_ready = 1'b1;
            ogs_d   = 1'b0;
          end else if (do_evict) begin
            r_valid = 1'b1;
            r_cmd   = BUS_WRBK;
            r_addr  = {cur_tag, idx, ev_w};
            r_data  = word_q;
            if (ev_last) begin
              ea_d  = 1'b0;
              ewi_d = '0;
              mwe   = 1'b1;
              mw_st = MESI_I;
            end else begin
              ea_d  = 1'b1;
              ewi_d = ev_w + off_t'(1);
            end
          end else begin
            miss_d  = 1'b1;
            paddr_d = it_addr_q;
            pw_d    = is_wr;
            pword_d = is_wr ? it_wdata_q : '0;
            r_valid = 1'b1;
            r_cmd   = is_wr ? BUS_RDX : BUS_RD;
            r_addr  = it_addr_q;
          end
        end
      end
      REQ_OBSERVE: begin
        if (own) begin
          ogs_d = 1'b1;
        end else begin
          if (snoop_hit && (it_cmd_q == BUS_RD || it_cmd_q == BUS_RDX)) begin
            if (cur_st == MESI_M) begin
              sfa_d    = 1'b1;
              sfbase_d = {it_baddr_q[ADDR_BITS-1:OFF_BITS], {OFF_BITS{1'b0}}};
              left_d   = LEFT_BITS'(LINE_WORDS);
            end
            mwe = 1'b1;
            if (it_cmd_q == BUS_RD) begin
              mw_st    = MESI_S;
              r_shared = 1'b1;
            end else begin
              mw_st = MESI_I;
            end
          end
          if (fill) begin
            wwe = 1'b1;
            wwd = it_bword_q;
            if (fill_last) begin
              mwe    = 1'b1;
              mw_tag = a_tag(it_baddr_q);
              mw_st  = pw_q ? MESI_M : (it_shared_q ? MESI_S : MESI_E);
              miss_d = 1'b0;
            end
          end
        end
      end
      default: begin
        if (sfa_q) begin
          if (left_q == '0 || left_q > LEFT_BITS'(LINE_WORDS)) begin
            sfa_d  = 1'b0;
            left_d = '0;
          end else begin
            r_valid = 1'b1;
            r_cmd   = BUS_WRBK;
            r_addr  = sfbase_q + ADDR_BITS'(tw);
            r_data  = word_q;
            left_d  = left_q - left_t'(1);
            if (left_q == left_t'(1)) begin
              sfa_d = 1'b0;
            end
          end
        end
      end
    endcase
    if (mwe) begin
      mvalid_d[idx] = 1'b1;
    end
    if (cmd_i.merge) begin
      wwe = 1'b1;
      wwa = {a_idx(it_baddr_q), a_off(paddr_q)};
      wwd = pword_q;
    end
    if (!cmd_i.exec) begin
      mwe = 1'b0;
      if (!cmd_i.merge) begin
        wwe = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ready_res_o     <= r_ready;
      read_data_o     <= r_rdata;
      bus_req_valid_o <= r_valid;
      bus_req_cmd_o   <= r_cmd;
      bus_req_addr_o  <= r_addr;
      bus_req_data_o  <= r_data;
      assert_shared_o <= r_shared;
    end
  end

endmodule

// File: hw/rtl/mesi_snooping_cache_controller_unit.sv
// Channel   Dir  Handshake           Beat
// req       in   valid/ready         one read, write, bus observation or tick
// rsp       out  valid/ready         one result word set
// apb       in   psel/penable/pwrite core_id register at byte 0
//
// After acceptance the controller steps through the tag/state read, word read and
// execute states, then holds the result valid until taken; a fill that completes a
// pending write adds a merge state (one extra word memory write) before the result.
// The tag/state memory and the word memory are single ported with registered reads.
// A new beat is accepted only after the previous result is taken.
// Reset clears all line states to Invalid through per-set valid flops.
module mesi_snooping_cache_controller_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  mscc_req_if.sink                     req,
  mscc_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mscc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import mscc_pkg::*;

  logic [1:0] core_id_q;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_CORE_ID[PADDR_W-1:2]) ? {30'd0, core_id_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_id_q <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == REG_CORE_ID[PADDR_W-1:2]) begin
      core_id_q <= pwdata[1:0];
    end
  end

  mscc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mscc_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .core_id_i       (core_id_q),
    .req_type_i      (req.req_type),
    .address_i       (req.address),
    .wr_word_i       (req.wr_word),
    .bus_cmd_i       (req.bus_cmd),
    .bus_origin_i    (req.bus_origin),
    .bus_address_i   (req.bus_address),
    .bus_word_i      (req.bus_word),
    .shr_line_i      (req.shr_line),
    .ready_res_o     (rsp.ready_res),
    .read_data_o     (rsp.read_data),
    .bus_req_valid_o (rsp.bus_req_valid),
    .bus_req_cmd_o   (rsp.bus_req_cmd),
    .bus_req_addr_o  (rsp.bus_req_addr),
    .bus_req_data_o  (rsp.bus_req_data),
    .assert_shared_o (rsp.assert_shared)
  );

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready) else $error("accept while result pending");

  a_no_req_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.bus_req_valid) |-> (rsp.bus_req_cmd == BUS_NONE &&
      rsp.bus_req_addr == '0 && rsp.bus_req_data == '0))
    else $error("bus request fields set without request");

  a_data_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && rsp.read_data != '0) |-> rsp.ready_res)
    else $error("read data without completion");

  a_accept_to_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !rsp.valid) else $error("result too early");

endmodule
